>>> src/vrd_pkg.sv
// Shared types and constants for the voltammetry record deframer.
// Used by vrd_parse and voltammetry_record_deframer_core; no dependencies.
`default_nettype none
package vrd_pkg;

  localparam int unsigned NAME_BYTES   = 15;
  localparam int unsigned HEADER_BYTES = 13;
  localparam int unsigned HDR_IDX_W    = 4;
  localparam int unsigned SMP_CNT_W    = 18;

  // Header byte positions
  localparam int unsigned HDR_FREQ   = 0;
  localparam int unsigned HDR_START  = 2;
  localparam int unsigned HDR_STOP   = 4;
  localparam int unsigned HDR_HEIGHT = 6;
  localparam int unsigned HDR_INCR   = 8;
  localparam int unsigned HDR_RANGE  = 10;
  localparam int unsigned HDR_COUNT  = 11;

  localparam logic [7:0] TYPE_SWV = 8'd0;

  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_NAME  = 2'd1,
    PH_BODY  = 2'd2,
    PH_CLOSE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_HEADER  = 2'd0,
    EV_PAIR    = 2'd1,
    EV_END     = 2'd2,
    EV_BADTYPE = 2'd3
  } event_t;

  typedef struct packed {
    event_t      event_res;
    logic [15:0] frequency;
    logic [15:0] start_level;
    logic [15:0] stop_level;
    logic [15:0] pulse_height;
    logic [15:0] step_increment;
    logic [7:0]  current_range;
    logic [15:0] sample_count;
    logic [15:0] pair_index;
    logic [15:0] forward_current;
    logic [15:0] reverse_current;
    logic [7:0]  closing_byte;
  } res_t;

endpackage
`default_nettype wire

>>> src/vrd_parse.sv
// Record parser: phase machine, header store and sample pairing.
// Depends on vrd_pkg.
`default_nettype none
module vrd_parse (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [7:0]   byte_i,
  output logic              res_valid,
  output vrd_pkg::res_t     res
);
  import vrd_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             name_cnt_r, name_cnt_nxt;
  logic [HDR_IDX_W-1:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]             hdr_r [HEADER_BYTES];
  logic [SMP_CNT_W-1:0]   smp_cnt_r, smp_cnt_nxt;
  logic [7:0]             part_r, part_nxt;
  logic [15:0]            fwd_r, fwd_nxt;

  logic [7:0]             hdr_view [HEADER_BYTES];
  logic                   hdr_fill;
  logic                   hdr_last;
  logic [15:0]            cnt_word;
  logic [SMP_CNT_W-1:0]   smp_last;
  logic [3:0]             name_inc;

  assign hdr_fill = (hdr_cnt_r < HDR_IDX_W'(HEADER_BYTES));
  assign hdr_last = (hdr_cnt_r == HDR_IDX_W'(HEADER_BYTES - 1));
  assign name_inc = name_cnt_r + 4'd1;

  // Header as it stands after this byte is stored
  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hdr_view[i] = (phase_r == PH_BODY && hdr_cnt_r == HDR_IDX_W'(i)) ? byte_i : hdr_r[i];
    end
  end

  assign cnt_word = {hdr_view[HDR_COUNT], hdr_view[HDR_COUNT+1]};
  assign smp_last = {cnt_word, 2'b00} - SMP_CNT_W'(1);

  // Next state
  always_comb begin
    phase_nxt    = phase_r;
    name_cnt_nxt = name_cnt_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    smp_cnt_nxt  = smp_cnt_r;
    part_nxt     = part_r;
    fwd_nxt      = fwd_r;
    if (step) begin
      unique case (phase_r)
        PH_TYPE: begin
          if (byte_i == TYPE_SWV) begin
            name_cnt_nxt = '0;
            hdr_cnt_nxt  = '0;
            smp_cnt_nxt  = '0;
            part_nxt     = '0;
            fwd_nxt      = '0;
            phase_nxt    = PH_NAME;
          end
        end
        PH_NAME: begin
          if (name_inc >= 4'(NAME_BYTES)) begin
            name_cnt_nxt = '0;
            hdr_cnt_nxt  = '0;
            smp_cnt_nxt  = '0;
            phase_nxt    = PH_BODY;
          end else begin
            name_cnt_nxt = name_inc;
          end
        end
        PH_BODY: begin
          if (hdr_fill) begin
            hdr_cnt_nxt = hdr_cnt_r + HDR_IDX_W'(1);
            if (hdr_last) begin
              smp_cnt_nxt = '0;
              // empty record: nothing but the closing byte follows
              if (cnt_word == 16'd0) phase_nxt = PH_CLOSE;
            end
          end else begin
            case (smp_cnt_r[1:0])
              2'd0, 2'd2: part_nxt = byte_i;
              2'd1:       fwd_nxt  = {part_r, byte_i};
              default:    ;
            endcase
            if (smp_cnt_r >= smp_last) phase_nxt = PH_CLOSE;
            smp_cnt_nxt = smp_cnt_r + SMP_CNT_W'(1);
          end
        end
        PH_CLOSE: phase_nxt = PH_TYPE;
        default:  phase_nxt = PH_TYPE;
      endcase
    end
  end

  // Result
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_TYPE: begin
        if (byte_i != TYPE_SWV) begin
          res_valid        = 1'b1;
          res.event_res    = EV_BADTYPE;
          res.closing_byte = byte_i;
        end
      end
      PH_BODY: begin
        res.frequency      = {hdr_view[HDR_FREQ],   hdr_view[HDR_FREQ+1]};
        res.start_level    = {hdr_view[HDR_START],  hdr_view[HDR_START+1]};
        res.stop_level     = {hdr_view[HDR_STOP],   hdr_view[HDR_STOP+1]};
        res.pulse_height   = {hdr_view[HDR_HEIGHT], hdr_view[HDR_HEIGHT+1]};
        res.step_increment = {hdr_view[HDR_INCR],   hdr_view[HDR_INCR+1]};
        res.current_range  = hdr_view[HDR_RANGE];
        res.sample_count   = cnt_word;
        if (hdr_fill) begin
          res_valid     = hdr_last;
          res.event_res = EV_HEADER;
        end else begin
          res_valid           = (smp_cnt_r[1:0] == 2'd3);
          res.event_res       = EV_PAIR;
          res.pair_index      = smp_cnt_r[SMP_CNT_W-1:2];
          res.forward_current = fwd_r;
          res.reverse_current = {part_r, byte_i};
        end
        if (!res_valid) res = '0;
      end
      PH_CLOSE: begin
        res_valid        = 1'b1;
        res.event_res    = EV_END;
        res.closing_byte = byte_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TYPE;
      name_cnt_r <= '0;
      hdr_cnt_r  <= '0;
      smp_cnt_r  <= '0;
      part_r     <= '0;
      fwd_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      name_cnt_r <= name_cnt_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      smp_cnt_r  <= smp_cnt_nxt;
      part_r     <= part_nxt;
      fwd_r      <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && phase_r == PH_BODY && hdr_fill) begin
      hdr_r[hdr_cnt_r] <= byte_i;
    end
  end

  a_bad_type: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TYPE && byte_i != TYPE_SWV) |-> (res_valid && res.event_res == EV_BADTYPE))
    else $error("bad type byte not reported");

  a_name_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_NAME) |-> (hdr_cnt_r == '0 && smp_cnt_r == '0))
    else $error("counters not cleared during name");

  a_close_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_CLOSE) |=> (phase_r == PH_TYPE))
    else $error("closing byte did not return to type wait");

endmodule
`default_nettype wire

>>> src/voltammetry_record_deframer_core.sv
// Voltammetry record deframer, top level: input register, parser, result register.
// Depends on vrd_pkg and vrd_parse.
`default_nettype none
// Takes one record byte per cycle with no gaps of its own; each byte passes an
// input register and one parse step into the result register that drives the
// outputs, and waits in the input register while a result is stalled.
// Bytes that complete the header, a sample pair, the closing byte or a rejected
// type byte give one result; all others give none.
// The result register lets the next request in while a result waits, so input
// stalls only when a byte is held behind a stalled result.
module voltammetry_record_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_event_res,
  output logic [15:0]      out_frequency,
  output logic [15:0]      out_start_level,
  output logic [15:0]      out_stop_level,
  output logic [15:0]      out_pulse_height,
  output logic [15:0]      out_step_increment,
  output logic [7:0]       out_current_range,
  output logic [15:0]      out_sample_count,
  output logic [15:0]      out_pair_index,
  output logic [15:0]      out_forward_current,
  output logic [15:0]      out_reverse_current,
  output logic [7:0]       out_closing_byte
);
  import vrd_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  res_t       out_res_r;
  logic       adv;
  logic       in_take;
  logic       res_valid;
  res_t       res;

  // Advance the held byte when the result slot is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  vrd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .byte_i    (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take)  s1_valid_r <= 1'b1;
      else if (adv) s1_valid_r <= 1'b0;
      if (adv)                          out_valid_r <= res_valid;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take)          s1_byte_r <= in_byte_in;
    if (adv && res_valid) out_res_r <= res;
  end

  assign out_valid           = out_valid_r;
  assign out_event_res       = out_res_r.event_res;
  assign out_frequency       = out_res_r.frequency;
  assign out_start_level     = out_res_r.start_level;
  assign out_stop_level      = out_res_r.stop_level;
  assign out_pulse_height    = out_res_r.pulse_height;
  assign out_step_increment  = out_res_r.step_increment;
  assign out_current_range   = out_res_r.current_range;
  assign out_sample_count    = out_res_r.sample_count;
  assign out_pair_index      = out_res_r.pair_index;
  assign out_forward_current = out_res_r.forward_current;
  assign out_reverse_current = out_res_r.reverse_current;
  assign out_closing_byte    = out_res_r.closing_byte;

  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("held request lost");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !adv)
    else $error("parse step while result stalled");

  a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r) |-> !in_stall)
    else $error("stall with empty input register");

endmodule
`default_nettype wire
